[sv/nca_pkg.sv]
// shared constants, payload types and helpers of the nearest center assign block
package nca_pkg;

   localparam int MAX_CENTERS = 64;
   localparam int MAX_DIMS    = 16;
   localparam int COORD_BITS  = 16;

   // field widths of the words on the ports
   localparam int OP_W    = 2;
   localparam int CSLOT_W = 6;
   localparam int DSLOT_W = 4;
   localparam int VALUE_W = 16;
   localparam int LABEL_W = 6;
   localparam int DIST_W  = 48;
   localparam int COST_W  = 64;
   localparam int PNUM_W  = 32;
   localparam int ACT_W   = 7;
   localparam int DIM_W   = 5;

   localparam int IDX_W       = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int CNT_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int KC_W        = $clog2(MAX_CENTERS + 1);
   localparam int DC_W        = $clog2(MAX_DIMS + 1);
   localparam int STORE_DEPTH = MAX_CENTERS * MAX_DIMS;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int EXT_W  = (COORD_BITS > VALUE_W) ? COORD_BITS : VALUE_W;
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_POINT = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic REG_ACTIVE = 1'b0;
   localparam logic REG_DIMS   = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [CSLOT_W-1:0]        center_slot;
      logic [DSLOT_W-1:0]        coord_slot;
      logic signed [VALUE_W-1:0] coord_value;
   } req_word_type;

   typedef struct packed {
      logic [LABEL_W-1:0] cluster_label;
      logic [DIST_W-1:0]  nearest_dist;
      logic [COST_W-1:0]  running_cost;
      logic [PNUM_W-1:0]  point_number;
      logic               cost_saturated;
   } rsp_word_type;

   typedef struct packed {
      logic [KC_W-1:0] active_centers;
      logic [DC_W-1:0] dimensions;
   } cfg_type;

   // sign-extend the port value, then wrap to the coordinate width
   function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [VALUE_W-1:0] raw);
      logic signed [EXT_W-1:0] ext;
      ext = EXT_W'(signed'(raw));
      return ext[COORD_BITS-1:0];
   endfunction

endpackage

[sv/nca_ram.sv]
// generic single write port, single read port ram with registered read
module nca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/nca_csr.sv]
// configuration registers behind the apb-style port, clamped on write
module nca_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [nca_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [nca_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [nca_pkg::CSR_DW-1:0] csr_prdata,
   output logic                      csr_pready,
   output nca_pkg::cfg_type          cfg
);
   import nca_pkg::*;

   logic [KC_W-1:0]  act_ff, act_in;
   logic [DC_W-1:0]  dim_ff, dim_in;
   logic [ACT_W-1:0] act_raw;
   logic [DIM_W-1:0] dim_raw;
   logic             wr;
   logic             reg_sel;

   assign wr      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[2];
   assign act_raw = csr_pwdata[ACT_W-1:0];
   assign dim_raw = csr_pwdata[DIM_W-1:0];

   always_comb begin
      act_in = act_ff;
      dim_in = dim_ff;
      if (wr && reg_sel == REG_ACTIVE) begin
         if (act_raw == '0) begin
            act_in = KC_W'(1);
         end else if (int'(act_raw) > MAX_CENTERS) begin
            act_in = KC_W'(MAX_CENTERS);
         end else begin
            act_in = KC_W'(act_raw);
         end
      end
      if (wr && reg_sel == REG_DIMS) begin
         if (dim_raw == '0) begin
            dim_in = DC_W'(1);
         end else if (int'(dim_raw) > MAX_DIMS) begin
            dim_in = DC_W'(MAX_DIMS);
         end else begin
            dim_in = DC_W'(dim_raw);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= KC_W'(1);
         dim_ff <= DC_W'(1);
      end else begin
         act_ff <= act_in;
         dim_ff <= dim_in;
      end
   end

   assign csr_prdata = (reg_sel == REG_ACTIVE) ? CSR_DW'(act_ff) : CSR_DW'(dim_ff);
   assign csr_pready = 1'b1;

   assign cfg.active_centers = act_ff;
   assign cfg.dimensions     = dim_ff;

endmodule

[sv/nca_engine.sv]
// sequencer, distance pipeline, statistics and result register around the two memories
module nca_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  nca_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nca_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nca_pkg::rsp_word_type rsp_word
);
   import nca_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // item context
   logic signed [COORD_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]             col_ff, col_in;
   logic                         final_ff, final_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [IDX_W-1:0]             last_ff, last_in;
   logic [CNT_W-1:0]             coord_cnt_ff, coord_cnt_in;

   // pipeline
   logic                s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]    s1_idx_ff, s1_idx_in;
   logic                s2_vld_ff, s2_vld_in;
   logic [IDX_W-1:0]    s2_idx_ff, s2_idx_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [DIST_W-1:0]   old_ff, old_in;
   logic [MAX_CENTERS-1:0] pd_valid_ff, pd_valid_in;

   logic [DIST_W-1:0]   best_ff, best_in;
   logic [IDX_W-1:0]    label_ff, label_in;

   // statistics
   logic [COST_W-1:0]   cost_ff, cost_in;
   logic [PNUM_W-1:0]   pnum_ff, pnum_in;
   logic                sat_ff, sat_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   // memory ports
   logic                  cs_wr_en;
   logic [STORE_AW-1:0]   cs_wr_addr;
   logic [COORD_BITS-1:0] cs_wr_data;
   logic [STORE_AW-1:0]   cs_rd_addr;
   logic [COORD_BITS-1:0] cs_rd_data;
   logic                  pd_wr_en;
   logic [DIST_W-1:0]     pd_rd_data;

   logic                  accept;
   logic                  is_last;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]     abs_diff;
   logic [SUM_W-1:0]      sum;
   logic [DIST_W-1:0]     sum_sat;
   logic [COST_W:0]       cost_sum;
   logic [COST_W-1:0]     cost_next;

   nca_ram #(.WIDTH(COORD_BITS), .DEPTH(STORE_DEPTH)) u_center_ram (
      .clock   (clock),
      .wr_en   (cs_wr_en),
      .wr_addr (cs_wr_addr),
      .wr_data (cs_wr_data),
      .rd_addr (cs_rd_addr),
      .rd_data (cs_rd_data)
   );

   nca_ram #(.WIDTH(DIST_W), .DEPTH(MAX_CENTERS)) u_partial_ram (
      .clock   (clock),
      .wr_en   (pd_wr_en),
      .wr_addr (s2_idx_ff),
      .wr_data (sum_sat),
      .rd_addr (idx_ff),
      .rd_data (pd_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_last   = (DC_W'(coord_cnt_ff) + DC_W'(1)) >= cfg.dimensions;

   assign cs_wr_addr = STORE_AW'(int'(req_word.center_slot) * MAX_DIMS + int'(req_word.coord_slot));
   assign cs_wr_data = to_coord(req_word.coord_value);
   assign cs_wr_en   = accept && req_word.operation == OP_LOAD
                       && int'(req_word.center_slot) < MAX_CENTERS
                       && int'(req_word.coord_slot) < MAX_DIMS;
   assign cs_rd_addr = STORE_AW'(int'(idx_ff) * MAX_DIMS + int'(col_ff));

   // stage 1: memory data is back, square the difference
   assign diff     = DIFF_W'(val_ff) - DIFF_W'(signed'(cs_rd_data));
   assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign sq_in    = SQ_W'(abs_diff) * SQ_W'(abs_diff);
   assign old_in   = pd_valid_ff[s1_idx_ff] ? pd_rd_data : '0;
   assign s2_vld_in = s1_vld_ff;
   assign s2_idx_in = s1_idx_ff;

   // stage 2: accumulate with saturation, write back or compare
   assign sum      = SUM_W'(old_ff) + SUM_W'(sq_ff);
   assign sum_sat  = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
   assign pd_wr_en = s2_vld_ff && !final_ff;

   assign cost_sum  = (COST_W + 1)'(cost_ff) + (COST_W + 1)'(best_ff);
   assign cost_next = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      col_in       = col_ff;
      final_in     = final_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      coord_cnt_in = coord_cnt_ff;
      s1_vld_in    = 1'b0;
      s1_idx_in    = idx_ff;
      pd_valid_in  = pd_valid_ff;
      best_in      = best_ff;
      label_in     = label_ff;
      cost_in      = cost_ff;
      pnum_in      = pnum_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      if (pd_wr_en) begin
         pd_valid_in[s2_idx_ff] = 1'b1;
      end
      if (s2_vld_ff && final_ff) begin
         if (s2_idx_ff == '0 || sum_sat < best_ff) begin
            best_in  = sum_sat;
            label_in = s2_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.operation == OP_CLEAR) begin
               cost_in = '0;
               pnum_in = '0;
               sat_in  = 1'b0;
            end
            if (accept && req_word.operation == OP_POINT) begin
               val_in   = to_coord(req_word.coord_value);
               col_in   = coord_cnt_ff;
               final_in = is_last;
               idx_in   = '0;
               last_in  = IDX_W'(cfg.active_centers - KC_W'(1));
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one center per cycle out of both memories
            s1_vld_in = 1'b1;
            if (idx_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               if (final_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  coord_cnt_in = coord_cnt_ff + CNT_W'(1);
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_FINISH: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_word_in.cluster_label    = LABEL_W'(label_ff);
               rsp_word_in.nearest_dist     = best_ff;
               rsp_word_in.running_cost     = cost_next;
               rsp_word_in.point_number     = pnum_ff;
               rsp_word_in.cost_saturated   = sat_ff || (cost_next == '1);
               cost_in      = cost_next;
               sat_in       = sat_ff || (cost_next == '1);
               pnum_in      = pnum_ff + PNUM_W'(1);
               coord_cnt_in = '0;
               pd_valid_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_cnt_ff <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         pd_valid_ff  <= '0;
         cost_ff      <= '0;
         pnum_ff      <= '0;
         sat_ff       <= 1'b0;
      end else begin
         coord_cnt_ff <= coord_cnt_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         pd_valid_ff  <= pd_valid_in;
         cost_ff      <= cost_in;
         pnum_ff      <= pnum_in;
         sat_ff       <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      col_ff    <= col_in;
      final_ff  <= final_in;
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      s1_idx_ff <= s1_idx_in;
      s2_idx_ff <= s2_idx_in;
      sq_ff     <= sq_in;
      old_ff    <= old_in;
      best_ff   <= best_in;
      label_ff  <= label_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[sv/nearest_center_assign_top.sv]
// top level of the k-means nearest center assign block
//
// Centers are loaded one coordinate per load word into a center memory; point words then
// stream a point's coordinates in order. Load and clear words never raise the stall. A point
// word walks the k active centers one per cycle through the center memory and the partial
// distance memory and holds the stall until it is through, and on a point's last coordinate
// it also builds the result word and stays busy for as long as the previous
// result still waits downstream. The result sits in an output register, so the next word
// is taken while a result still waits downstream. Ties go to the lowest center index;
// partial distances saturate at 2^48-1 and the total cost at 2^64-1, with a sticky flag
// that a clear word resets. Unloaded center entries read as undefined.
module nearest_center_assign_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  nca_pkg::req_word_type      req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output nca_pkg::rsp_word_type      rsp_word,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [nca_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [nca_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [nca_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import nca_pkg::*;

   cfg_type cfg;

   nca_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   nca_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // a flagged cost is pinned at its maximum
   a_sat_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.cost_saturated) |-> (rsp_word.running_cost == '1))
      else $error("saturation flag without full cost");

   a_label_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_word.cluster_label) < int'(cfg.active_centers)))
      else $error("label beyond active centers");

   // a point word always starts a scan
   a_point_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_word.operation == OP_POINT) |=> req_stall)
      else $error("point word did not occupy the engine");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a point in flight");

endmodule
